// File: rtl/tcfo_pkg.sv
// ----------------------------------------------------------------------------
// tcfo_pkg: shared types and constants for the two-class oldest-first queue
// Command and status codes, queue entry layout and pointer helpers.
// ----------------------------------------------------------------------------
package tcfo_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int STAMP_BITS  = 16;
  localparam int VALUE_W     = 32;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    CMD_ADMIT      = 2'd0,
    CMD_TAKE_ANY   = 2'd1,
    CMD_TAKE_POS   = 2'd2,
    CMD_TAKE_OTHER = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_ADMITTED  = 2'd0,
    ST_DELIVERED = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [STAMP_BITS-1:0]     stamp;
  } entry_t;

  // queue state seen by the top level
  typedef struct packed {
    logic   nonempty;
    logic   full;
    entry_t head;
  } qstat_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    n = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    return n;
  endfunction

endpackage

// File: rtl/tcfo_if.sv
// ----------------------------------------------------------------------------
// tcfo_if: valid/ready channels of the two-class oldest-first queue
// Command channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
interface tcfo_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic signed [31:0] item_value;

  modport source (output valid, command, item_value, input ready);
  modport sink   (input valid, command, item_value, output ready);
endinterface

interface tcfo_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic signed [31:0] out_value;

  modport source (output valid, status, out_value, input ready);
  modport sink   (input valid, status, out_value, output ready);
endinterface

// File: rtl/tcfo_class_queue.sv
// ----------------------------------------------------------------------------
// tcfo_class_queue: one class FIFO with a registered head entry
// Memory read is issued for the next head every cycle so a pop can follow a
// pop; a write to the address being read is forwarded into the head register.
// ----------------------------------------------------------------------------
module tcfo_class_queue
  import tcfo_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output qstat_t qstat
);

  entry_t           mem [QUEUE_DEPTH];
  entry_t           head_entry;
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic [PTR_W-1:0] rd_addr;

  // look one entry ahead when the current head leaves
  assign rd_addr = pop ? ptr_next(head) : head;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_data;
    end
    if (push && (tail == rd_addr)) begin
      head_entry <= push_data;
    end else begin
      head_entry <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail  <= ptr_next(tail);
        count <= count + CNT_W'(1);
      end else if (pop) begin
        head  <= ptr_next(head);
        count <= count - CNT_W'(1);
      end
    end
  end

  assign qstat.nonempty = (count != '0);
  assign qstat.full     = (count == CNT_FULL);
  assign qstat.head     = head_entry;

`ifndef SYNTH
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push |-> count != CNT_FULL)
    else $error("push into full queue");

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    !(push && pop))
    else $error("push and pop in one cycle");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    pop |=> count == $past(count) - CNT_W'(1))
    else $error("count did not drop after pop");
`endif

endmodule

// File: rtl/two_class_fifo_oldest_first_top.sv
// ----------------------------------------------------------------------------
// two_class_fifo_oldest_first_top: two-class queue served oldest first
// Positive items and non-positive items queue apart; take-any picks the
// older head by arrival stamp.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one command word: admit item_value, take oldest of either
//   class, take positive, or take non-positive. res returns exactly one word
//   per command: status (admitted, delivered, nothing available, full and
//   dropped) and out_value, which is zero unless an item is delivered.
//   Result valid rises in the cycle after command accept. Throughput is
//   one command per cycle unless res stalls: each class keeps its head
//   entry in a register reloaded from the queue memory's single read port
//   every cycle, so back-to-back takes need no wait.
//   Each queue holds QUEUE_DEPTH entries; arrival stamps are STAMP_BITS wide
//   and compared modulo their width.
//   Reset empties both queues and clears the arrival stamp; memory contents
//   are not cleared, and no clearing pass is needed.
//   When the receiver stalls, the result register holds its word and cmd
//   ready falls until the word is taken.
// ----------------------------------------------------------------------------
module two_class_fifo_oldest_first_top
  import tcfo_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  tcfo_cmd_if.sink   cmd,
  tcfo_res_if.source res
);

  qstat_t                 pos_stat;
  qstat_t                 oth_stat;
  logic                   pos_push;
  logic                   pos_pop;
  logic                   oth_push;
  logic                   oth_pop;
  entry_t                 push_data;
  logic [STAMP_BITS-1:0]  arrival_stamp;
  logic                   res_valid;
  status_t                res_status;
  logic signed [31:0]     res_value;
  status_t                status_next;
  logic signed [31:0]     value_next;
  logic                   accept;
  logic                   is_pos;
  logic [STAMP_BITS-1:0]  stamp_diff;
  logic                   pos_older;

  assign cmd.ready = !res_valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;

  assign is_pos     = !cmd.item_value[31] && (cmd.item_value != '0);
  assign stamp_diff = pos_stat.head.stamp - oth_stat.head.stamp;
  assign pos_older  = stamp_diff[STAMP_BITS-1];

  assign push_data.value = cmd.item_value;
  assign push_data.stamp = arrival_stamp;

  always_comb begin
    pos_push    = 1'b0;
    oth_push    = 1'b0;
    pos_pop     = 1'b0;
    oth_pop     = 1'b0;
    status_next = ST_EMPTY;
    if (accept) begin
      unique case (cmd_t'(cmd.command))
        CMD_ADMIT: begin
          if (is_pos) begin
            pos_push    = !pos_stat.full;
            status_next = pos_stat.full ? ST_FULL : ST_ADMITTED;
          end else begin
            oth_push    = !oth_stat.full;
            status_next = oth_stat.full ? ST_FULL : ST_ADMITTED;
          end
        end
        CMD_TAKE_ANY: begin
          if (pos_stat.nonempty && oth_stat.nonempty) begin
            pos_pop = pos_older;
            oth_pop = !pos_older;
          end else begin
            pos_pop = pos_stat.nonempty;
            oth_pop = oth_stat.nonempty;
          end
        end
        CMD_TAKE_POS:   pos_pop = pos_stat.nonempty;
        CMD_TAKE_OTHER: oth_pop = oth_stat.nonempty;
        default: ;
      endcase
      if (pos_pop || oth_pop) begin
        status_next = ST_DELIVERED;
      end
    end
  end

  always_comb begin
    if (pos_pop) begin
      value_next = pos_stat.head.value;
    end else if (oth_pop) begin
      value_next = oth_stat.head.value;
    end else begin
      value_next = '0;
    end
  end

  tcfo_class_queue u_pos_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (pos_push),
    .push_data (push_data),
    .pop       (pos_pop),
    .qstat     (pos_stat)
  );

  tcfo_class_queue u_oth_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (oth_push),
    .push_data (push_data),
    .pop       (oth_pop),
    .qstat     (oth_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      arrival_stamp <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (pos_push || oth_push) begin
        arrival_stamp <= arrival_stamp + STAMP_BITS'(1);
      end
      if (accept) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_status <= status_next;
      res_value  <= value_next;
    end
  end

  assign res.valid     = res_valid;
  assign res.status    = res_status;
  assign res.out_value = res_value;

`ifndef SYNTH
  a_zero_unless_delivered: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_status != ST_DELIVERED) |-> res_value == '0)
    else $error("value set on a word without delivery");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> res_valid)
    else $error("accepted command gave no result");

  a_admit_status: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.command == CMD_ADMIT) |=>
      (res_status == ST_ADMITTED || res_status == ST_FULL))
    else $error("admit answered with a take status");

  a_stamp_step: assert property (@(posedge clk) disable iff (rst)
    (pos_push || oth_push) |=> arrival_stamp == $past(arrival_stamp) + STAMP_BITS'(1))
    else $error("arrival stamp did not advance");
`endif

endmodule
